// File: design/hm_pkg.sv
// hm_pkg: shared constants, types and codes of the dual-path hitless merge core
// no dependencies
`default_nettype none
package hm_pkg;

   localparam int BUFFER_DEPTH    = 256;
   localparam int PASS_FIFO_DEPTH = 64;
   localparam int SLOT_W          = $clog2(BUFFER_DEPTH);
   localparam int OFF_W           = SLOT_W + 1;
   localparam int OCC_W           = SLOT_W + 1;
   localparam int FIFO_W          = $clog2(PASS_FIFO_DEPTH);
   localparam int FCNT_W          = FIFO_W + 1;
   localparam int SCAN_LANES      = 8;
   localparam int LANE_W          = $clog2(SCAN_LANES);
   localparam int SEQ_W           = 16;
   localparam int HANDLE_W        = 16;
   localparam int TIME_W          = 32;
   localparam int CNT_W           = 32;
   localparam int SKEW_SUM_W      = 37;
   localparam int SLOT_DATA_W     = HANDLE_W + TIME_W;
   localparam logic [SEQ_W-1:0] SEQ_HALF = 16'd32768;

   localparam int CNT_NUM       = 6;
   localparam int CNT_PATH_A    = 0;
   localparam int CNT_PATH_B    = 1;
   localparam int CNT_DELIVERED = 2;
   localparam int CNT_DUPLICATE = 3;
   localparam int CNT_LOST      = 4;
   localparam int CNT_RECOVERED = 5;

   localparam logic [1:0] CSR_MERGE_ENABLED = 2'd0;
   localparam logic [1:0] CSR_MAX_BUFFERED  = 2'd1;
   localparam logic [1:0] CSR_DIFF_DELAY    = 2'd2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_CHECK,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      MD_DUP,
      MD_DROP,
      MD_POP_EXP,
      MD_POP_SKIP,
      MD_FIFO
   } mode_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [OFF_W-1:0] offset;
   } scan_status_type;

endpackage
`default_nettype wire

// File: design/hm_ram.sv
// hm_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module hm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: design/hm_oldest_scan.sv
// hm_oldest_scan: finds the first valid slot at or after a base, a few lanes per cycle
// depends on hm_pkg
`default_nettype none
module hm_oldest_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [hm_pkg::SLOT_W-1:0]         base,
   input  wire logic [hm_pkg::BUFFER_DEPTH-1:0]   valid_vec,
   output hm_pkg::scan_status_type                status
);
   logic                       busy_ff, busy_in;
   logic [hm_pkg::OFF_W-1:0]   off_ff, off_in;
   logic                       hit;
   logic [hm_pkg::LANE_W-1:0]  first;
   logic                       last;

   always_comb begin
      logic [hm_pkg::SLOT_W-1:0] idx;
      hit   = 1'b0;
      first = '0;
      idx   = '0;
      // descending so the lowest lane wins
      for (int k = hm_pkg::SCAN_LANES - 1; k >= 0; k--) begin
         idx = base + off_ff[hm_pkg::SLOT_W-1:0] + hm_pkg::SLOT_W'(k);
         if (valid_vec[idx]) begin
            hit   = 1'b1;
            first = hm_pkg::LANE_W'(k);
         end
      end
      last = (off_ff + hm_pkg::OFF_W'(hm_pkg::SCAN_LANES)) >=
             hm_pkg::OFF_W'(hm_pkg::BUFFER_DEPTH);
      status.done   = busy_ff && (hit || last);
      status.found  = hit;
      status.offset = off_ff + hm_pkg::OFF_W'(first);
      busy_in = busy_ff;
      off_in  = off_ff;
      if (start) begin
         busy_in = 1'b1;
         off_in  = '0;
      end else if (status.done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         off_in = off_ff + hm_pkg::OFF_W'(hm_pkg::SCAN_LANES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         off_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         off_ff  <= off_in;
      end
   end
endmodule
`default_nettype wire

// File: design/hm_skew_div.sv
// hm_skew_div: shift-add division by ten with saturation to 32 bits, one step per cycle
// depends on hm_pkg
`default_nettype none
module hm_skew_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [hm_pkg::SKEW_SUM_W-1:0]   dividend,
   output logic                                 done,
   output logic      [31:0]                     quotient
);
   localparam int W = hm_pkg::SKEW_SUM_W;
   localparam logic [2:0] STEP_ADD4  = 3'd0;
   localparam logic [2:0] STEP_ADD8  = 3'd1;
   localparam logic [2:0] STEP_ADD16 = 3'd2;
   localparam logic [2:0] STEP_ADD32 = 3'd3;
   localparam logic [2:0] STEP_SCALE = 3'd4;
   localparam logic [2:0] STEP_REM   = 3'd5;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [2:0]    step_ff, step_in;
   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;

   // q ~ n * 0.8 refined by shifted adds, then scaled by 1/8 and fixed up once
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_ADD4;
         num_in  = dividend;
         quo_in  = (dividend >> 1) + (dividend >> 2);
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            STEP_ADD4:  quo_in = quo_ff + (quo_ff >> 4);
            STEP_ADD8:  quo_in = quo_ff + (quo_ff >> 8);
            STEP_ADD16: quo_in = quo_ff + (quo_ff >> 16);
            STEP_ADD32: quo_in = quo_ff + (quo_ff >> 32);
            STEP_SCALE: quo_in = quo_ff >> 3;
            STEP_REM:   rem_in = num_ff - ((quo_ff << 3) + (quo_ff << 1));
            default: begin
               // estimate is low by at most one
               quo_in  = quo_ff + W'(rem_ff > W'(9));
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = (|quo_ff[W-1:32]) ? 32'hFFFF_FFFF : quo_ff[31:0];
endmodule
`default_nettype wire

// File: design/dual_path_hitless_merge_core.sv
// dual_path_hitless_merge_core: top level of the two-path hitless merge
// depends on hm_pkg, hm_ram, hm_oldest_scan, hm_skew_div
//
//   channel | direction | handshake     | carries
//   req_    | in        | valid / stall | push or pop transaction
//   rsp_    | out       | valid / stall | one result per request, with statistics
//   csr_    | in        | valid / ready | register index and write data
//
// one request at a time: accept, evaluate, then the slot read, the oldest-slot scan
// (8 slots per cycle) or the shift-add divide by ten for the skew update, as needed
// synchronous active-high reset; slot valid bits clear at once, rams are not cleared
// req_stall is high while a request is in flight; a stalled result holds its value
`default_nettype none
module dual_path_hitless_merge_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic        req_path_b,
   input  wire logic [15:0] req_seq_number,
   input  wire logic [15:0] req_payload_handle,
   input  wire logic [31:0] req_now_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_result_kind,
   output logic             rsp_success,
   output logic [15:0]      rsp_out_seq,
   output logic [15:0]      rsp_out_handle,
   output logic [31:0]      rsp_path_a_total,
   output logic [31:0]      rsp_path_b_total,
   output logic [31:0]      rsp_delivered_total,
   output logic [31:0]      rsp_duplicate_total,
   output logic [31:0]      rsp_lost_total,
   output logic [31:0]      rsp_recovered_total,
   output logic [31:0]      rsp_skew_estimate,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int SW = hm_pkg::SLOT_W;

   // sequencer
   hm_pkg::state_type state_ff, state_in;
   hm_pkg::mode_type  mode_ff, mode_in;

   // captured transaction
   logic        op_ff, pb_ff;
   logic [15:0] seq_ff, handle_ff;
   logic [31:0] now_ff;

   // configuration
   logic        merge_en_ff, merge_en_in;
   logic [8:0]  cap_ff, cap_in;
   logic [29:0] delay_ff, delay_in;

   // merge state
   logic                              started_ff, started_in;
   logic [15:0]                       exp_ff, exp_in;
   logic [hm_pkg::BUFFER_DEPTH-1:0]   valid_ff, valid_in;
   logic [hm_pkg::OCC_W-1:0]          occ_ff, occ_in;
   logic [hm_pkg::FCNT_W-1:0]         fcnt_ff, fcnt_in;
   logic [hm_pkg::FIFO_W-1:0]         frd_ff, frd_in;
   logic [31:0]                       counters_ff [hm_pkg::CNT_NUM];
   logic [31:0]                       counters_in [hm_pkg::CNT_NUM];
   logic [31:0]                       skew_ff, skew_in;

   // candidate for delivery
   logic [15:0]              cand_seq_ff, cand_seq_in;
   logic [hm_pkg::OFF_W-1:0] cand_off_ff, cand_off_in;

   // pending result
   logic        res_ok_ff, res_ok_in;
   logic [15:0] res_seq_ff, res_seq_in;
   logic [15:0] res_handle_ff, res_handle_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_ok_ff;
   logic [15:0] rsp_seq_ff, rsp_handle_ff;
   logic [31:0] rsp_cnt_ff [hm_pkg::CNT_NUM];
   logic [31:0] rsp_skew_ff;
   logic        rsp_load;

   // slot ram: {handle, arrival}
   logic                            sram_we, sram_re;
   logic [SW-1:0]                   sram_waddr, sram_raddr;
   logic [hm_pkg::SLOT_DATA_W-1:0]  sram_wdata, sram_rdata;

   // pass-through fifo ram
   logic                            fram_we, fram_re;
   logic [hm_pkg::FIFO_W-1:0]       fram_waddr;
   logic [hm_pkg::HANDLE_W-1:0]     fram_rdata;

   // shared units
   logic                            scan_start;
   logic [SW-1:0]                   scan_base;
   hm_pkg::scan_status_type         scan_status;
   logic                            div_start, div_done;
   logic [hm_pkg::SKEW_SUM_W-1:0]   div_value;
   logic [31:0]                     div_quotient;

   // evaluation helpers
   logic [15:0] exp_eff, diff, scan_seq;
   logic [31:0] wait_ticks;
   logic [10:0] cap_x3;

   hm_ram #(.WIDTH(hm_pkg::SLOT_DATA_W), .DEPTH(hm_pkg::BUFFER_DEPTH)) u_slot_ram (
      .clock  (clock),
      .wr_en  (sram_we),
      .wr_addr(sram_waddr),
      .wr_data(sram_wdata),
      .rd_en  (sram_re),
      .rd_addr(sram_raddr),
      .rd_data(sram_rdata)
   );

   hm_ram #(.WIDTH(hm_pkg::HANDLE_W), .DEPTH(hm_pkg::PASS_FIFO_DEPTH)) u_fifo_ram (
      .clock  (clock),
      .wr_en  (fram_we),
      .wr_addr(fram_waddr),
      .wr_data(handle_ff),
      .rd_en  (fram_re),
      .rd_addr(frd_ff),
      .rd_data(fram_rdata)
   );

   hm_oldest_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .base     (scan_base),
      .valid_vec(valid_ff),
      .status   (scan_status)
   );

   hm_skew_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_value),
      .done    (div_done),
      .quotient(div_quotient)
   );

   assign req_stall = (state_ff != hm_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      // sequence compare against the expected number, seeded by the first push
      exp_eff    = started_ff ? exp_ff : seq_ff;
      diff       = seq_ff - exp_eff;
      scan_seq   = exp_ff + 16'(scan_status.offset);
      wait_ticks = now_ff - sram_rdata[31:0];
      cap_x3     = 11'(cap_ff) * 11'd3;
      div_value  = ({5'b0, skew_ff} << 3) + {5'b0, skew_ff} +
                   {1'b0, wait_ticks, 4'b0} + hm_pkg::SKEW_SUM_W'(5);
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      merge_en_in   = merge_en_ff;
      cap_in        = cap_ff;
      delay_in      = delay_ff;
      started_in    = started_ff;
      exp_in        = exp_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      fcnt_in       = fcnt_ff;
      frd_in        = frd_ff;
      counters_in   = counters_ff;
      skew_in       = skew_ff;
      cand_seq_in   = cand_seq_ff;
      cand_off_in   = cand_off_ff;
      res_ok_in     = res_ok_ff;
      res_seq_in    = res_seq_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      sram_we       = 1'b0;
      sram_waddr    = seq_ff[SW-1:0];
      sram_wdata    = {handle_ff, now_ff};
      sram_re       = 1'b0;
      sram_raddr    = seq_ff[SW-1:0];
      fram_we       = 1'b0;
      fram_waddr    = frd_ff + fcnt_ff[hm_pkg::FIFO_W-1:0];
      fram_re       = 1'b0;
      scan_start    = 1'b0;
      scan_base     = exp_eff[SW-1:0];
      div_start     = 1'b0;

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr_valid) begin
         case (csr_index)
            hm_pkg::CSR_MERGE_ENABLED: merge_en_in = csr_data[0];
            hm_pkg::CSR_MAX_BUFFERED:  cap_in      = csr_data[8:0];
            hm_pkg::CSR_DIFF_DELAY:    delay_in    = csr_data[29:0];
            default: ;
         endcase
      end

      case (state_ff)
         hm_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_ok_in     = 1'b0;
               res_seq_in    = '0;
               res_handle_in = '0;
               state_in      = hm_pkg::ST_EVAL;
            end
         end

         hm_pkg::ST_EVAL: begin
            state_in = hm_pkg::ST_RESP;
            if (op_ff == hm_pkg::OP_PUSH) begin
               if (pb_ff) begin
                  counters_in[hm_pkg::CNT_PATH_B] = counters_ff[hm_pkg::CNT_PATH_B] + 32'd1;
               end else begin
                  counters_in[hm_pkg::CNT_PATH_A] = counters_ff[hm_pkg::CNT_PATH_A] + 32'd1;
               end
               if (!merge_en_ff) begin
                  if (fcnt_ff < hm_pkg::FCNT_W'(hm_pkg::PASS_FIFO_DEPTH)) begin
                     fram_we   = 1'b1;
                     fcnt_in   = fcnt_ff + hm_pkg::FCNT_W'(1);
                     res_ok_in = 1'b1;
                     counters_in[hm_pkg::CNT_DELIVERED] =
                        counters_ff[hm_pkg::CNT_DELIVERED] + 32'd1;
                  end
               end else begin
                  started_in = 1'b1;
                  exp_in     = exp_eff;
                  if (diff > hm_pkg::SEQ_HALF) begin
                     // stale: behind the expected number
                     counters_in[hm_pkg::CNT_DUPLICATE] =
                        counters_ff[hm_pkg::CNT_DUPLICATE] + 32'd1;
                  end else if (diff >= 16'(hm_pkg::BUFFER_DEPTH)) begin
                     // beyond the reorder window
                     counters_in[hm_pkg::CNT_LOST] = counters_ff[hm_pkg::CNT_LOST] + 32'd1;
                  end else if (valid_ff[seq_ff[SW-1:0]]) begin
                     // duplicate of a held packet: fetch its arrival for the skew
                     counters_in[hm_pkg::CNT_DUPLICATE] =
                        counters_ff[hm_pkg::CNT_DUPLICATE] + 32'd1;
                     sram_re  = 1'b1;
                     mode_in  = hm_pkg::MD_DUP;
                     state_in = hm_pkg::ST_CHECK;
                  end else begin
                     sram_we                  = 1'b1;
                     valid_in[seq_ff[SW-1:0]] = 1'b1;
                     occ_in                   = occ_ff + hm_pkg::OCC_W'(1);
                     res_ok_in                = 1'b1;
                     if (pb_ff) begin
                        counters_in[hm_pkg::CNT_RECOVERED] =
                           counters_ff[hm_pkg::CNT_RECOVERED] + 32'd1;
                     end
                     // over the cap: drop the oldest held entry
                     if ((occ_ff + hm_pkg::OCC_W'(1)) > hm_pkg::OCC_W'(cap_ff)) begin
                        scan_start = 1'b1;
                        mode_in    = hm_pkg::MD_DROP;
                        state_in   = hm_pkg::ST_SCAN;
                     end
                  end
               end
            end else begin
               if (!merge_en_ff) begin
                  if (fcnt_ff != '0) begin
                     fram_re   = 1'b1;
                     frd_in    = frd_ff + hm_pkg::FIFO_W'(1);
                     fcnt_in   = fcnt_ff - hm_pkg::FCNT_W'(1);
                     res_ok_in = 1'b1;
                     mode_in   = hm_pkg::MD_FIFO;
                     state_in  = hm_pkg::ST_CHECK;
                  end
               end else if (occ_ff != '0) begin
                  if (valid_ff[exp_ff[SW-1:0]]) begin
                     sram_re     = 1'b1;
                     sram_raddr  = exp_ff[SW-1:0];
                     cand_seq_in = exp_ff;
                     cand_off_in = '0;
                     mode_in     = hm_pkg::MD_POP_EXP;
                     state_in    = hm_pkg::ST_CHECK;
                  end else begin
                     scan_start = 1'b1;
                     scan_base  = exp_ff[SW-1:0];
                     mode_in    = hm_pkg::MD_POP_SKIP;
                     state_in   = hm_pkg::ST_SCAN;
                  end
               end
            end
         end

         hm_pkg::ST_SCAN: begin
            scan_base = exp_ff[SW-1:0];
            if (scan_status.done) begin
               state_in = hm_pkg::ST_RESP;
               if (scan_status.found) begin
                  if (mode_ff == hm_pkg::MD_DROP) begin
                     valid_in[scan_seq[SW-1:0]] = 1'b0;
                     occ_in = occ_ff - hm_pkg::OCC_W'(1);
                     exp_in = scan_seq + 16'd1;
                     counters_in[hm_pkg::CNT_LOST] = counters_ff[hm_pkg::CNT_LOST] + 32'd1;
                  end else begin
                     sram_re     = 1'b1;
                     sram_raddr  = scan_seq[SW-1:0];
                     cand_seq_in = scan_seq;
                     cand_off_in = scan_status.offset;
                     state_in    = hm_pkg::ST_CHECK;
                  end
               end
            end
         end

         hm_pkg::ST_CHECK: begin
            state_in = hm_pkg::ST_RESP;
            case (mode_ff)
               hm_pkg::MD_FIFO: res_handle_in = fram_rdata;
               hm_pkg::MD_DUP: begin
                  div_start = 1'b1;
                  state_in  = hm_pkg::ST_DIV;
               end
               hm_pkg::MD_POP_EXP, hm_pkg::MD_POP_SKIP: begin
                  if ((mode_ff == hm_pkg::MD_POP_EXP &&
                       (wait_ticks >= 32'(delay_ff) || occ_ff > hm_pkg::OCC_W'(cap_ff >> 1))) ||
                      (mode_ff == hm_pkg::MD_POP_SKIP &&
                       (wait_ticks >= {1'b0, delay_ff, 1'b0} ||
                        occ_ff > hm_pkg::OCC_W'(cap_x3 >> 2)))) begin
                     valid_in[cand_seq_ff[SW-1:0]] = 1'b0;
                     occ_in        = occ_ff - hm_pkg::OCC_W'(1);
                     exp_in        = cand_seq_ff + 16'd1;
                     res_ok_in     = 1'b1;
                     res_seq_in    = cand_seq_ff;
                     res_handle_in = sram_rdata[hm_pkg::SLOT_DATA_W-1:hm_pkg::TIME_W];
                     counters_in[hm_pkg::CNT_DELIVERED] =
                        counters_ff[hm_pkg::CNT_DELIVERED] + 32'd1;
                     // skipped numbers count as lost
                     counters_in[hm_pkg::CNT_LOST] =
                        counters_ff[hm_pkg::CNT_LOST] + 32'(cand_off_ff);
                  end
               end
               default: ;
            endcase
         end

         hm_pkg::ST_DIV: begin
            if (div_done) begin
               skew_in  = div_quotient;
               state_in = hm_pkg::ST_RESP;
            end
         end

         hm_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = hm_pkg::ST_IDLE;
            end
         end

         default: state_in = hm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hm_pkg::ST_IDLE;
         mode_ff      <= hm_pkg::MD_DUP;
         merge_en_ff  <= 1'b1;
         cap_ff       <= 9'd256;
         delay_ff     <= '0;
         started_ff   <= 1'b0;
         exp_ff       <= '0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         fcnt_ff      <= '0;
         frd_ff       <= '0;
         skew_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < hm_pkg::CNT_NUM; i++) begin
            counters_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         merge_en_ff  <= merge_en_in;
         cap_ff       <= cap_in;
         delay_ff     <= delay_in;
         started_ff   <= started_in;
         exp_ff       <= exp_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         fcnt_ff      <= fcnt_in;
         frd_ff       <= frd_in;
         skew_ff      <= skew_in;
         rsp_valid_ff <= rsp_valid_in;
         counters_ff  <= counters_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == hm_pkg::ST_IDLE && req_valid) begin
         op_ff     <= req_op;
         pb_ff     <= req_path_b;
         seq_ff    <= req_seq_number;
         handle_ff <= req_payload_handle;
         now_ff    <= req_now_time;
      end
      cand_seq_ff   <= cand_seq_in;
      cand_off_ff   <= cand_off_in;
      res_ok_ff     <= res_ok_in;
      res_seq_ff    <= res_seq_in;
      res_handle_ff <= res_handle_in;
      if (rsp_load) begin
         rsp_kind_ff   <= op_ff;
         rsp_ok_ff     <= res_ok_ff;
         rsp_seq_ff    <= res_seq_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_cnt_ff    <= counters_ff;
         rsp_skew_ff   <= skew_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_success         = rsp_ok_ff;
   assign rsp_out_seq         = rsp_seq_ff;
   assign rsp_out_handle      = rsp_handle_ff;
   assign rsp_path_a_total    = rsp_cnt_ff[hm_pkg::CNT_PATH_A];
   assign rsp_path_b_total    = rsp_cnt_ff[hm_pkg::CNT_PATH_B];
   assign rsp_delivered_total = rsp_cnt_ff[hm_pkg::CNT_DELIVERED];
   assign rsp_duplicate_total = rsp_cnt_ff[hm_pkg::CNT_DUPLICATE];
   assign rsp_lost_total      = rsp_cnt_ff[hm_pkg::CNT_LOST];
   assign rsp_recovered_total = rsp_cnt_ff[hm_pkg::CNT_RECOVERED];
   assign rsp_skew_estimate   = rsp_skew_ff;
endmodule
`default_nettype wire

// File: design/hm_checker.sv
// hm_checker: port-level checks of the merge core, bound to the top level
// depends on hm_pkg and dual_path_hitless_merge_core
`default_nettype none
module hm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_result_kind,
   input wire logic [15:0] rsp_out_seq,
   input wire logic [15:0] rsp_out_handle,
   input wire logic [31:0] rsp_lost_total
);
   // a transaction in flight blocks the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous in flight");

   // push answers never carry packet data
   a_push_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == hm_pkg::OP_PUSH |-> rsp_out_seq == 16'd0 &&
      rsp_out_handle == 16'd0)
      else $error("push result carries packet data");

   // reset leaves no result valid
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays valid and its lost total holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lost_total))
      else $error("stalled result changed");
endmodule

bind dual_path_hitless_merge_core hm_checker u_hm_checker (.*);
`default_nettype wire

// File: bench/tb_dual_path_hitless_merge_core.sv
// tb_dual_path_hitless_merge_core: self-checking bench of the two-path hitless merge core
// depends on hm_pkg and dual_path_hitless_merge_core
`default_nettype none

typedef struct {
   logic        kind;
   logic        success;
   logic [15:0] seq;
   logic [15:0] handle;
   logic [31:0] totals [6];
   logic [31:0] skew;
} merge_result_type;

class merge_scoreboard;
   // register copies
   bit          merge_on;
   bit [8:0]    cap;
   bit [29:0]   delay;
   // predicted block state
   bit          running;
   bit [15:0]   next_seq;
   bit          held [256];
   bit [15:0]   held_handle [256];
   bit [31:0]   held_time [256];
   int unsigned fill;
   bit [15:0]   fifo [64];
   int unsigned fifo_count;
   int unsigned fifo_rd;
   bit [31:0]   totals [6];
   bit [31:0]   skew;
   merge_result_type pending [$];
   int          errors;

   function void clear();
      merge_on = 1'b1; cap = 9'd256; delay = '0;
      running = 1'b0; next_seq = '0; fill = 0; fifo_count = 0; fifo_rd = 0; skew = '0;
      foreach (held[i]) held[i] = 1'b0;
      foreach (totals[i]) totals[i] = '0;
      pending.delete();
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == hm_pkg::CSR_MERGE_ENABLED) merge_on = val[0];
      else if (idx == hm_pkg::CSR_MAX_BUFFERED) cap = val[8:0];
      else if (idx == hm_pkg::CSR_DIFF_DELAY) delay = val[29:0];
   endfunction

   function int unsigned oldest_gap();
      for (int d = 0; d < 256; d++)
         if (held[8'(next_seq + d)]) return d;
      return 256;
   endfunction

   function bit push_packet(bit pb, bit [15:0] sq, bit [15:0] h, bit [31:0] now);
      bit [15:0] diff;
      bit [7:0] s;
      bit [63:0] v;
      int unsigned d;
      if (!running) begin
         running = 1'b1;
         next_seq = sq;
      end
      diff = sq - next_seq;
      if (diff > 16'd32768) begin
         totals[hm_pkg::CNT_DUPLICATE]++;
         return 1'b0;
      end
      if (diff >= 256) begin
         totals[hm_pkg::CNT_LOST]++;
         return 1'b0;
      end
      s = sq[7:0];
      if (held[s]) begin
         totals[hm_pkg::CNT_DUPLICATE]++;
         v = (64'(skew) * 9 + (64'(32'(now - held_time[s])) << 4) + 5) / 10;
         skew = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
         return 1'b0;
      end
      held[s] = 1'b1; held_handle[s] = h; held_time[s] = now;
      fill++;
      if (pb) totals[hm_pkg::CNT_RECOVERED]++;
      if (fill > cap) begin
         d = oldest_gap();
         if (d < 256) begin
            held[8'(next_seq + d)] = 1'b0;
            fill--;
            next_seq = 16'(next_seq + d + 1);
            totals[hm_pkg::CNT_LOST]++;
         end
      end
      return 1'b1;
   endfunction

   function bit pop_packet(bit [31:0] now, output bit [15:0] sq, output bit [15:0] h);
      bit [7:0] s;
      int unsigned d;
      bit [15:0] target;
      sq = '0; h = '0;
      if (fill == 0) return 1'b0;
      s = next_seq[7:0];
      if (held[s]) begin
         if (32'(now - held_time[s]) >= 32'(delay) || fill > cap / 2) begin
            sq = next_seq; h = held_handle[s];
            held[s] = 1'b0; fill--; next_seq++;
            totals[hm_pkg::CNT_DELIVERED]++;
            return 1'b1;
         end
         return 1'b0;
      end
      d = oldest_gap();
      if (d >= 256) return 1'b0;
      target = 16'(next_seq + d);
      s = target[7:0];
      if (32'(now - held_time[s]) >= 32'(delay) * 2 || fill > (32'(cap) * 3) / 4) begin
         totals[hm_pkg::CNT_LOST] += d;
         sq = target; h = held_handle[s];
         held[s] = 1'b0; fill--; next_seq = target + 16'd1;
         totals[hm_pkg::CNT_DELIVERED]++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // an accepted request: work out and queue its result
   function void note_request(bit op, bit pb, bit [15:0] sq, bit [15:0] h, bit [31:0] now);
      merge_result_type r;
      bit [15:0] os, oh;
      r.kind = op; r.success = 1'b0; r.seq = '0; r.handle = '0;
      if (op == hm_pkg::OP_PUSH) begin
         if (pb) totals[hm_pkg::CNT_PATH_B]++;
         else totals[hm_pkg::CNT_PATH_A]++;
         if (!merge_on) begin
            if (fifo_count < 64) begin
               fifo[(fifo_rd + fifo_count) % 64] = h;
               fifo_count++;
               totals[hm_pkg::CNT_DELIVERED]++;
               r.success = 1'b1;
            end
         end else r.success = push_packet(pb, sq, h, now);
      end else if (!merge_on) begin
         if (fifo_count > 0) begin
            r.handle = fifo[fifo_rd];
            fifo_rd = (fifo_rd + 1) % 64;
            fifo_count--;
            r.success = 1'b1;
         end
      end else begin
         r.success = pop_packet(now, os, oh);
         r.seq = os; r.handle = oh;
      end
      foreach (totals[i]) r.totals[i] = totals[i];
      r.skew = skew;
      pending.push_back(r);
   endfunction

   function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_result(merge_result_type got);
      merge_result_type w;
      string names [6] = '{"path_a_total", "path_b_total", "delivered_total",
                           "duplicate_total", "lost_total", "recovered_total"};
      if (pending.size() == 0) begin
         $error("result with no request outstanding");
         errors++;
         return;
      end
      w = pending[0];
      pending.delete(0);
      compare("result_kind", w.kind, got.kind);
      compare("success", w.success, got.success);
      compare("out_seq", w.seq, got.seq);
      compare("out_handle", w.handle, got.handle);
      for (int i = 0; i < 6; i++) compare(names[i], w.totals[i], got.totals[i]);
      compare("skew_estimate", w.skew, got.skew);
   endfunction
endclass

module tb_dual_path_hitless_merge_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = 1'b0;
   logic        req_path_b = 1'b0;
   logic [15:0] req_seq_number = '0;
   logic [15:0] req_payload_handle = '0;
   logic [31:0] req_now_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind, rsp_success;
   logic [15:0] rsp_out_seq, rsp_out_handle;
   logic [31:0] rsp_path_a_total, rsp_path_b_total, rsp_delivered_total;
   logic [31:0] rsp_duplicate_total, rsp_lost_total, rsp_recovered_total;
   logic [31:0] rsp_skew_estimate;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   dual_path_hitless_merge_core i_dut (.*);

   merge_scoreboard merge_sb = new();

   // idling knobs, percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_off = 1'b0;    // long receiver hold-off to back the block up
   int unsigned idle_cycles = 0;    // cycles without any transaction
   bit [31:0]   tick = '0;
   bit [15:0]   seq_base = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: random stall, or a steady one during hold-off, sampled at the rising edge
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      merge_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_result_kind;
         got.success = rsp_success;
         got.seq = rsp_out_seq;
         got.handle = rsp_out_handle;
         got.totals = '{rsp_path_a_total, rsp_path_b_total, rsp_delivered_total,
                        rsp_duplicate_total, rsp_lost_total, rsp_recovered_total};
         got.skew = rsp_skew_estimate;
         merge_sb.check_result(got);
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** dual_path_hitless_merge_core: FAILED **");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      merge_sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one request transaction; valid is held across back-to-back sends
   task automatic send(bit op, bit pb, bit [15:0] sq, bit [15:0] h, bit [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_op <= op; req_path_b <= pb;
      req_seq_number <= sq; req_payload_handle <= h; req_now_time <= now;
      do @(posedge clock); while (req_stall);
      merge_sb.note_request(op, pb, sq, h, now);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (merge_sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // well-formed dual-path traffic with random loss, reorder and noise
   task automatic traffic(int n, int unsigned pop_pct);
      bit [15:0] sq;
      for (int i = 0; i < n; i++) begin
         tick += $urandom_range(40);
         case ($urandom_range(19))
            0: send(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
            1: send(hm_pkg::OP_PUSH, 1'($urandom), 16'(seq_base + $urandom_range(400)),
                    16'($urandom), tick);
            default: begin
               if ($urandom_range(99) < pop_pct)
                  send(hm_pkg::OP_POP, 1'($urandom), 16'($urandom), 16'd0, tick);
               else begin
                  sq = 16'(seq_base + $urandom_range(6));
                  if ($urandom_range(4) == 0) seq_base++;
                  send(hm_pkg::OP_PUSH, $urandom_range(3) == 0, sq, 16'($urandom), tick);
                  if ($urandom_range(2) != 0)
                     send(hm_pkg::OP_PUSH, 1'b1, sq, 16'($urandom),
                          tick + $urandom_range(200));
               end
            end
         endcase
      end
      drain();
   endtask

   initial begin
      merge_sb.clear();
      merge_sb.errors = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: start at the sequence wrap, duplicates, stale, out of window
      send(hm_pkg::OP_POP, 0, 0, 0, 0);
      send(hm_pkg::OP_PUSH, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0);
      send(hm_pkg::OP_PUSH, 1, 16'hFFFF, 16'h0001, 32'h0000_0010);
      send(hm_pkg::OP_PUSH, 1, 16'h0001, 16'h1234, 32'h20);
      send(hm_pkg::OP_PUSH, 0, 16'hFFFE, 16'h0, 32'h20);
      send(hm_pkg::OP_PUSH, 0, 16'h00FF, 16'h5555, 32'h30);
      send(hm_pkg::OP_PUSH, 0, 16'h7FFF, 16'hAAAA, 32'h30);
      send(hm_pkg::OP_PUSH, 1, 16'h8000, 16'h0, 32'h30);
      send(hm_pkg::OP_POP, 0, 0, 0, 32'h40);
      send(hm_pkg::OP_POP, 0, 0, 0, 32'h40);
      send(hm_pkg::OP_POP, 0, 0, 0, 32'hFFFF_FFFF);
      send(hm_pkg::OP_PUSH, 1, 16'h0001, 16'h0, 32'hFFFF_FFFF);
      drain();
      // long delay holds the expected packet, then the skip rule
      write_csr(hm_pkg::CSR_DIFF_DELAY, 32'h3FFF_FFFF);
      write_csr(hm_pkg::CSR_MAX_BUFFERED, 4);
      send(hm_pkg::OP_PUSH, 0, 16'h0004, 16'h0044, 32'h100);
      send(hm_pkg::OP_PUSH, 0, 16'h0003, 16'h0033, 32'h100);
      send(hm_pkg::OP_POP, 0, 0, 0, 32'h101);
      send(hm_pkg::OP_PUSH, 0, 16'h0006, 16'h0066, 32'h100);
      send(hm_pkg::OP_POP, 0, 0, 0, 32'h101);
      send(hm_pkg::OP_PUSH, 0, 16'h0007, 16'h0077, 32'h100);
      send(hm_pkg::OP_PUSH, 0, 16'h0008, 16'h0088, 32'h100);
      send(hm_pkg::OP_POP, 0, 0, 0, 32'h101);
      drain();
      // cap of zero and cap of one
      write_csr(hm_pkg::CSR_MAX_BUFFERED, 0);
      send(hm_pkg::OP_PUSH, 0, 16'h000A, 16'h00AA, 32'h200);
      drain();
      write_csr(hm_pkg::CSR_MAX_BUFFERED, 1);
      send(hm_pkg::OP_PUSH, 1, 16'h000C, 16'h00CC, 32'h200);
      send(hm_pkg::OP_POP, 0, 0, 0, 32'h200);
      drain();
      // pass-through: fill past the fifo depth, then empty it
      write_csr(hm_pkg::CSR_MERGE_ENABLED, 0);
      for (int i = 0; i < 66; i++)
         send(hm_pkg::OP_PUSH, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
      for (int i = 0; i < 66; i++) send(hm_pkg::OP_POP, 0, 0, 0, $urandom);
      drain();
      write_csr(hm_pkg::CSR_MERGE_ENABLED, 1);
      write_csr(hm_pkg::CSR_MAX_BUFFERED, 256);
      write_csr(hm_pkg::CSR_DIFF_DELAY, 0);
      seq_base = merge_sb.next_seq;
      tick = 32'hFFFF_F000;

      // random phases over idling patterns and register settings
      send_idle_pct = 0;  recv_stall_pct = 0;  traffic(70, 45);
      write_csr(hm_pkg::CSR_DIFF_DELAY, 50);
      write_csr(hm_pkg::CSR_MAX_BUFFERED, 16);
      send_idle_pct = 81; recv_stall_pct = 0;  traffic(65, 40);
      write_csr(hm_pkg::CSR_DIFF_DELAY, 0);
      write_csr(hm_pkg::CSR_MAX_BUFFERED, 511);
      send_idle_pct = 0;  recv_stall_pct = 81; traffic(65, 50);
      write_csr(hm_pkg::CSR_MERGE_ENABLED, 0);
      send_idle_pct = 36; recv_stall_pct = 36; traffic(45, 50);
      write_csr(hm_pkg::CSR_MERGE_ENABLED, 1);
      write_csr(hm_pkg::CSR_MAX_BUFFERED, 6);
      write_csr(hm_pkg::CSR_DIFF_DELAY, 200);
      seq_base = merge_sb.next_seq;
      send_idle_pct = 36; recv_stall_pct = 36; traffic(65, 35);

      // back-pressure: hold the result side while requests keep coming
      send_idle_pct = 0; recv_stall_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         traffic(25, 40);
      join

      drain();
      if (merge_sb.errors == 0 && merge_sb.pending.size() == 0)
         $display("** dual_path_hitless_merge_core: PASSED **");
      else
         $display("** dual_path_hitless_merge_core: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
design/hm_pkg.sv
design/hm_ram.sv
design/hm_oldest_scan.sv
design/hm_skew_div.sv
design/dual_path_hitless_merge_core.sv
design/hm_checker.sv
bench/tb_dual_path_hitless_merge_core.sv
